@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, but also checked while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/cpdp_pkg.sv @@
package cpdp_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int QSEL_W = 3;
    localparam int NQ_W   = 3;

    localparam logic [NQ_W-1:0] NQ_RESET = 3'd5;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CNOT  = 2'd2;

    localparam logic REG_NUM_QUBITS = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_CNOT,
        OP_ERR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic [QSEL_W-1:0] ctl;
        logic [QSEL_W-1:0] tgt;
        logic [NQ_W-1:0]   nq;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_G_IDX,
        S_G_RD1,
        S_G_RD2,
        S_G_WR1,
        S_G_WR2,
        S_G_NEXT
    } back_state_t;

    function automatic logic [DATA_W-1:0] neg_sat(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] most_neg;
        most_neg = {1'b1, {(DATA_W-1){1'b0}}};
        if (v == most_neg)
            return ~most_neg;
        return ~v + 1'b1;
    endfunction

endpackage

@@ rtl/core/cpdp_if.sv @@
interface cpdp_in_if;
    import cpdp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DATA_W-1:0]  real_in;
    logic signed [DATA_W-1:0]  imag_in;
    logic [QSEL_W-1:0]         control_qubit;
    logic [QSEL_W-1:0]         target_qubit;

    modport source (output valid, action, entry_index, real_in, imag_in,
                    control_qubit, target_qubit, input ready);
    modport sink (input valid, action, entry_index, real_in, imag_in,
                  control_qubit, target_qubit, output ready);
endinterface

interface cpdp_out_if;
    import cpdp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  real_out;
    logic signed [DATA_W-1:0]  imag_out;
    logic                      status;

    modport source (output valid, real_out, imag_out, status, input ready);
    modport sink (input valid, real_out, imag_out, status, output ready);
endinterface

@@ rtl/core/cnot_packed_density_permute_unit.sv @@
// Channel  Direction  Payload
// in_ch    sink       action, entry_index, real_in, imag_in, control_qubit, target_qubit
// out_ch   source     real_out, imag_out, status
// apb      slave      num_qubits at address 0
//
// A write or an error is completed from S_IDLE in the back end, and a read also passes S_READ,
// through the registered read port of the matrix memory.
// A gate sweeps every packed entry: a skipped entry passes S_G_IDX, S_G_RD1 and S_G_NEXT;
// a swapped one adds S_G_RD2, S_G_WR1 and S_G_WR2, all on the single memory read port.
// rst_n is asynchronous; the memory contents are not cleared by reset.
// A two-entry queue lets transfers in continue while the back end works or out_ch stalls.
module cnot_packed_density_permute_unit #(
    parameter int MAX_QUBITS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    cpdp_in_if.sink     in_ch,
    cpdp_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpdp_pkg::*;

    logic [NQ_W-1:0] num_qubits_reg;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;
    cmd_t            push_cmd;
    cmd_t            head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_QUBITS) ? {29'd0, num_qubits_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_qubits_reg <= NQ_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_NUM_QUBITS))
            num_qubits_reg <= pwdata[NQ_W-1:0];
    end

    cpdp_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
        .in_ch      (in_ch),
        .num_qubits (num_qubits_reg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    cpdp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_valid),
        .head      (head_cmd)
    );

    cpdp_back #(.MAX_QUBITS(MAX_QUBITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

@@ rtl/core/cpdp_front.sv @@
module cpdp_front #(
    parameter int MAX_QUBITS = 5
) (
    cpdp_in_if.sink                    in_ch,
    input  logic [cpdp_pkg::NQ_W-1:0]  num_qubits,
    input  logic                       queue_full,
    output logic                       push,
    output cpdp_pkg::cmd_t             cmd
);
    import cpdp_pkg::*;

    localparam int CW = 2 * MAX_QUBITS;
    localparam int KW = (CW > IDX_W) ? CW : IDX_W;

    logic          nq_ok;
    logic          idx_ok;
    logic          qubits_ok;
    logic [CW-1:0] count;
    logic [3:0]    sh_hi;
    logic [3:0]    sh_lo;

    // dim*(dim+1)/2 is 2^(2n-1) + 2^(n-1).
    assign sh_hi = {num_qubits, 1'b0} - 4'd1;
    assign sh_lo = {1'b0, num_qubits} - 4'd1;
    assign count = (CW'(1) << sh_hi) + (CW'(1) << sh_lo);

    assign nq_ok     = (num_qubits >= NQ_W'(2)) && (32'(num_qubits) <= MAX_QUBITS);
    assign idx_ok    = KW'(in_ch.entry_index) < KW'(count);
    assign qubits_ok = (in_ch.control_qubit < num_qubits)
                    && (in_ch.target_qubit < num_qubits)
                    && (in_ch.control_qubit != in_ch.target_qubit);

    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    always_comb
    begin
        cmd.idx = in_ch.entry_index;
        cmd.re  = in_ch.real_in;
        cmd.im  = in_ch.imag_in;
        cmd.ctl = in_ch.control_qubit;
        cmd.tgt = in_ch.target_qubit;
        cmd.nq  = num_qubits;
        cmd.op  = OP_ERR;
        if (nq_ok)
        begin
            unique case (in_ch.action)
                ACT_WRITE: cmd.op = idx_ok ? OP_WRITE : OP_ERR;
                ACT_READ:  cmd.op = idx_ok ? OP_READ : OP_ERR;
                ACT_CNOT:  cmd.op = qubits_ok ? OP_CNOT : OP_ERR;
                default:   cmd.op = OP_ERR;
            endcase
        end
    end

endmodule

@@ rtl/core/cpdp_fifo.sv @@
`include "assert_macros.svh"

module cpdp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpdp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output cpdp_pkg::cmd_t  head
);
    import cpdp_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    `ASSERT_CLK(a_no_overflow, push |-> !full, "push into a full queue")
    `ASSERT_CLK(a_no_underflow, pop |-> not_empty, "pop from an empty queue")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= 2'd2, "queue count out of range")

endmodule

@@ rtl/core/cpdp_back.sv @@
`include "assert_macros.svh"

module cpdp_back #(
    parameter int MAX_QUBITS = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  cpdp_pkg::cmd_t  cmd,
    output logic            pop,
    cpdp_out_if.source      out_ch
);
    import cpdp_pkg::*;

    localparam int QW    = MAX_QUBITS;
    localparam int DIM   = 1 << MAX_QUBITS;
    localparam int DEPTH = DIM * (DIM + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 2 * MAX_QUBITS + 2;
    localparam int EW    = 2 * DATA_W;

    back_state_t state_reg, state_next;

    logic [EW-1:0]     mem [DEPTH];
    logic [EW-1:0]     rdata_reg;
    logic [EW-1:0]     ddata_reg;
    cmd_t              cmd_reg;
    logic [QW-1:0]     r_reg;
    logic [QW-1:0]     c_reg;
    logic [AW-1:0]     d_reg;
    logic [AW-1:0]     s_reg;
    logic              trans_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_re_reg;
    logic [DATA_W-1:0] out_im_reg;
    logic              out_status_reg;

    logic          we;
    logic [AW-1:0] wa;
    logic [EW-1:0] wd;
    logic [AW-1:0] ra;
    logic          finish;

    logic [QW:0]   dimv;
    logic [QW-1:0] lastv;
    logic [QW-1:0] pr;
    logic [QW-1:0] pc;
    logic [QW-1:0] ra_row;
    logic [QW-1:0] ra_col;
    logic          trans;
    logic [PW-1:0] prod;
    logic [AW-1:0] s_calc;

    function automatic logic [QW-1:0] flip(input logic [QW-1:0] x,
                                           input logic [QSEL_W-1:0] ctl,
                                           input logic [QSEL_W-1:0] tgt);
        logic sel;
        sel = |((x >> ctl) & QW'(1));
        return sel ? (x ^ (QW'(1) << tgt)) : x;
    endfunction

    function automatic logic [EW-1:0] conj(input logic [EW-1:0] v, input logic t);
        return t ? {v[EW-1:DATA_W], neg_sat(v[DATA_W-1:0])} : v;
    endfunction

    assign dimv  = (QW+1)'(1) << cmd_reg.nq;
    assign lastv = QW'(dimv - (QW+1)'(1));

    // Canonical lower-triangle source of the current destination entry.
    assign pr     = flip(r_reg, cmd_reg.ctl, cmd_reg.tgt);
    assign pc     = flip(c_reg, cmd_reg.ctl, cmd_reg.tgt);
    assign trans  = pr < pc;
    assign ra_row = trans ? pc : pr;
    assign ra_col = trans ? pr : pc;
    assign prod   = PW'(ra_col) * (PW'({dimv, 1'b1}) - PW'(ra_col));
    assign s_calc = AW'(prod >> 1) + AW'(ra_row - ra_col);

    assign pop = (state_reg == S_IDLE) && cmd_valid && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        we     = 1'b0;
        wa     = d_reg;
        wd     = conj(rdata_reg, trans_reg);
        ra     = d_reg;
        finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                wa = AW'(cmd.idx);
                wd = {cmd.re, cmd.im};
                ra = AW'(cmd.idx);
                if (pop)
                begin
                    unique case (cmd.op)
                        OP_WRITE: we = 1'b1;
                        OP_READ:  state_next = S_READ;
                        OP_CNOT:  state_next = S_G_IDX;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
                state_next = S_IDLE;
            S_G_IDX:
                state_next = S_G_RD1;
            S_G_RD1:
            begin
                // Each swap pair is done once, from its lower packed index.
                if ((s_reg < d_reg) || ((s_reg == d_reg) && !trans_reg))
                    state_next = S_G_NEXT;
                else
                    state_next = S_G_RD2;
            end
            S_G_RD2:
            begin
                ra = s_reg;
                state_next = S_G_WR1;
            end
            S_G_WR1:
            begin
                we = 1'b1;
                state_next = S_G_WR2;
            end
            S_G_WR2:
            begin
                we = 1'b1;
                wa = s_reg;
                wd = conj(ddata_reg, trans_reg);
                state_next = S_G_NEXT;
            end
            S_G_NEXT:
            begin
                if ((r_reg == lastv) && (c_reg == lastv))
                begin
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_G_IDX;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
            r_reg   <= '0;
            c_reg   <= '0;
            d_reg   <= '0;
        end
        if (state_reg == S_G_IDX)
        begin
            s_reg     <= s_calc;
            trans_reg <= trans;
        end
        if (state_reg == S_G_RD2)
            ddata_reg <= rdata_reg;
        if ((state_reg == S_G_NEXT) && !finish)
        begin
            d_reg <= d_reg + AW'(1);
            if (r_reg == lastv)
            begin
                c_reg <= c_reg + QW'(1);
                r_reg <= c_reg + QW'(1);
            end
            else
                r_reg <= r_reg + QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((pop && (cmd.op != OP_READ) && (cmd.op != OP_CNOT))
                 || (state_reg == S_READ) || finish)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_re_reg     <= '0;
            out_im_reg     <= '0;
            out_status_reg <= (cmd.op == OP_ERR);
        end
        else if (state_reg == S_READ)
        begin
            out_re_reg     <= rdata_reg[EW-1:DATA_W];
            out_im_reg     <= rdata_reg[DATA_W-1:0];
            out_status_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_re_reg     <= '0;
            out_im_reg     <= '0;
            out_status_reg <= 1'b0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.real_out = out_re_reg;
    assign out_ch.imag_out = out_im_reg;
    assign out_ch.status   = out_status_reg;

    `ASSERT_CLK(a_pop_needs_room, pop |-> !out_valid_reg,
                "command taken while a result is still pending")
    `ASSERT_CLK(a_read_follows, (pop && (cmd.op == OP_READ)) |=> (state_reg == S_READ),
                "read did not move to the read data state")
    `ASSERT_CLK(a_gate_no_result, (state_reg == S_G_WR1) |-> !out_valid_reg,
                "result pending during a gate sweep")

endmodule
